FILE: src/kspcd_pkg.sv
`timescale 1ns / 1ps

package kspcd_pkg;

	localparam int MAX_SEQUENCE_DEF  = 6;
	localparam int COUNT_ENTRIES_DEF = 4;
	localparam int TYPE_W            = 5;
	localparam int CODE_W            = 10;
	localparam int VALUE_W           = 32;
	localparam int CODE_SLOTS        = 6;
	localparam int CODES_W           = CODE_SLOTS * CODE_W;
	localparam int POS_W             = 3;
	localparam int ENABLES_W         = 4;
	localparam int KIND_LEN_W        = 9;
	localparam int CNT_W             = 8;
	localparam int WIN_W             = 16;
	localparam int ENTRY_W           = 9;
	localparam int TABLE_ENTRIES     = 4;
	localparam int TABLE_W           = TABLE_ENTRIES * ENTRY_W;
	localparam int CFG_DATA_W        = 60;

	localparam logic [WIN_W-1:0]  DEFAULT_WINDOW = 16'd2000;
	localparam logic [TYPE_W-1:0] TYPE_KEY       = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_REL       = 5'd2;
	localparam logic [CODE_W-1:0] AXIS_X         = 10'd0;
	localparam logic              ACTION_EVENT   = 1'b0;
	localparam logic              ACTION_TICK    = 1'b1;
	localparam logic [CNT_W-1:0]  COUNT_MAX      = 8'd255;

	localparam int EN_SEQUENCE = 0;
	localparam int EN_ROTARY   = 1;
	localparam int EN_COUNT    = 2;
	localparam int EN_DEBUG    = 3;

	typedef enum logic [2:0] {
		REG_ENABLES,
		REG_SEQ_CODES,
		REG_SEQ_LENGTH,
		REG_ROT_CODES,
		REG_ROT_KIND_LEN,
		REG_COUNT_KEY,
		REG_COUNT_WINDOW,
		REG_COUNT_TABLE
	} reg_index_t;

	typedef struct packed {
		logic                      action;
		logic [TYPE_W-1:0]         event_type;
		logic [CODE_W-1:0]         event_code;
		logic signed [VALUE_W-1:0] event_value;
	} item_t;

	typedef struct packed {
		logic               enable;
		logic               debug;
		logic [CODE_W-1:0]  key_code;
		logic [WIN_W-1:0]   window_ticks;
		logic [TABLE_W-1:0] entries;
	} count_cfg_t;

	function automatic logic [POS_W-1:0] fit_len(input logic [POS_W-1:0] len,
			input logic [POS_W-1:0] max_len);
		logic [POS_W-1:0] r;
		if (len == '0)
			r = POS_W'(1);
		else if (len > max_len)
			r = max_len;
		else
			r = len;
		return r;
	endfunction

	function automatic logic [CODE_W-1:0] code_at(input logic [CODES_W-1:0] codes,
			input logic [POS_W-1:0] idx);
		logic [POS_W-1:0] j;
		j = (idx >= POS_W'(CODE_SLOTS)) ? idx - POS_W'(CODE_SLOTS) : idx;
		return codes[CODE_W*j +: CODE_W];
	endfunction

endpackage

FILE: src/kspcd_counter.sv
`timescale 1ns / 1ps

module kspcd_counter #(
	parameter int COUNT_ENTRIES = kspcd_pkg::COUNT_ENTRIES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  kspcd_pkg::item_t                      item,
	input  kspcd_pkg::count_cfg_t                 cfg,
	output logic [kspcd_pkg::TABLE_ENTRIES-1:0]   mask
);
	import kspcd_pkg::*;

	logic [CNT_W-1:0]         count_q;
	logic                     open_q;
	logic [WIN_W-1:0]         remaining_q;
	logic                     press;
	logic                     tick;
	logic                     expire;
	logic [TABLE_ENTRIES-1:0] hit;

	assign press = step && (item.action == ACTION_EVENT) && (item.event_type == TYPE_KEY)
		&& cfg.enable && (item.event_code == cfg.key_code) && (item.event_value != '0);
	assign tick   = step && (item.action == ACTION_TICK) && open_q;
	assign expire = tick && (remaining_q <= WIN_W'(1));

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
		if (i < COUNT_ENTRIES) begin : g_used
			assign hit[i] = (cfg.entries[ENTRY_W*i +: CNT_W] == count_q)
				&& (cfg.entries[ENTRY_W*i + CNT_W] || cfg.debug);
		end else begin : g_unused
			assign hit[i] = 1'b0;
		end
	end

	assign mask = expire ? hit : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			open_q      <= 1'b0;
			remaining_q <= '0;
		end else if (expire) begin
			count_q     <= '0;
			open_q      <= 1'b0;
			remaining_q <= '0;
		end else if (tick) begin
			remaining_q <= remaining_q - WIN_W'(1);
		end else if (press) begin
			if (!open_q) begin
				count_q     <= CNT_W'(1);
				open_q      <= 1'b1;
				remaining_q <= cfg.window_ticks;
			end else if (count_q < COUNT_MAX) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/key_sequence_and_press_count_detector.sv
`timescale 1ns / 1ps
// An accepted item is held in the input register and its result then in the result register.
// Throughput: one item per cycle; while a finished result waits under stall
// the input register holds and the input stalls once it is full.
// Reset: arst_n clears positions, the press window, valids and loads the
// configuration registers with their reset values.

module key_sequence_and_press_count_detector #(
	parameter int MAX_SEQUENCE  = kspcd_pkg::MAX_SEQUENCE_DEF,
	parameter int COUNT_ENTRIES = kspcd_pkg::COUNT_ENTRIES_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       event_valid,
	output logic                                       event_stall,
	input  logic                                       action,
	input  logic [kspcd_pkg::TYPE_W-1:0]               event_type,
	input  logic [kspcd_pkg::CODE_W-1:0]               event_code,
	input  logic signed [kspcd_pkg::VALUE_W-1:0]       event_value,
	output logic                                       result_valid,
	input  logic                                       result_stall,
	output logic                                       sequence_fired,
	output logic                                       rotary_fired,
	output logic [kspcd_pkg::TABLE_ENTRIES-1:0]        count_fired_mask,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [2:0]                                 cfg_index,
	input  logic [kspcd_pkg::CFG_DATA_W-1:0]           cfg_data
);
	import kspcd_pkg::*;

	logic [ENABLES_W-1:0]     enables_q;
	logic [CODES_W-1:0]       seq_codes_q;
	logic [POS_W-1:0]         seq_len_q;
	logic [CODES_W-1:0]       rot_codes_q;
	logic [KIND_LEN_W-1:0]    rot_kind_len_q;
	logic [CODE_W-1:0]        count_key_q;
	logic [WIN_W-1:0]         count_window_q;
	logic [TABLE_W-1:0]       count_table_q;

	item_t                    item_s1;
	logic                     valid_s1;
	logic                     advance;

	logic [POS_W-1:0]         seq_pos_q;
	logic [POS_W-1:0]         rot_pos_q;
	logic [POS_W-1:0]         seq_pos_d;
	logic [POS_W-1:0]         rot_pos_d;
	logic [POS_W-1:0]         seq_len;
	logic [POS_W-1:0]         rot_len;
	logic [POS_W-1:0]         seq_next;
	logic [POS_W-1:0]         rot_next;
	logic                     is_key;
	logic                     is_rel;
	logic                     seq_fire;
	logic                     rot_fire;
	logic [TABLE_ENTRIES-1:0] mask;
	count_cfg_t               count_cfg;

	logic                     result_valid_q;
	logic                     seq_fired_q;
	logic                     rot_fired_q;
	logic [TABLE_ENTRIES-1:0] mask_q;

	assign cfg_ready   = 1'b1;
	assign advance     = valid_s1 && (!result_valid_q || !result_stall);
	assign event_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q      <= '0;
			seq_codes_q    <= '0;
			seq_len_q      <= POS_W'(1);
			rot_codes_q    <= '0;
			rot_kind_len_q <= KIND_LEN_W'(64);
			count_key_q    <= '0;
			count_window_q <= DEFAULT_WINDOW;
			count_table_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_ENABLES:      enables_q      <= cfg_data[ENABLES_W-1:0];
				REG_SEQ_CODES:    seq_codes_q    <= cfg_data[CODES_W-1:0];
				REG_SEQ_LENGTH:   seq_len_q      <= cfg_data[POS_W-1:0];
				REG_ROT_CODES:    rot_codes_q    <= cfg_data[CODES_W-1:0];
				REG_ROT_KIND_LEN: rot_kind_len_q <= cfg_data[KIND_LEN_W-1:0];
				REG_COUNT_KEY:    count_key_q    <= cfg_data[CODE_W-1:0];
				REG_COUNT_WINDOW: count_window_q <= cfg_data[WIN_W-1:0];
				REG_COUNT_TABLE:  count_table_q  <= cfg_data[TABLE_W-1:0];
				default:          ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!event_stall) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			item_s1.action      <= action;
			item_s1.event_type  <= event_type;
			item_s1.event_code  <= event_code;
			item_s1.event_value <= event_value;
		end
	end

	always_comb begin
		seq_len  = fit_len(seq_len_q, POS_W'(MAX_SEQUENCE));
		rot_len  = fit_len(rot_kind_len_q[KIND_LEN_W-1 -: POS_W], POS_W'(MAX_SEQUENCE));
		is_key   = (item_s1.action == ACTION_EVENT) && (item_s1.event_type == TYPE_KEY);
		is_rel   = (item_s1.action == ACTION_EVENT) && (item_s1.event_type == TYPE_REL);
		seq_next = seq_pos_q + POS_W'(1);
		rot_next = rot_pos_q + POS_W'(1);
		seq_pos_d = seq_pos_q;
		rot_pos_d = rot_pos_q;
		seq_fire  = 1'b0;
		rot_fire  = 1'b0;

		if (is_key && enables_q[EN_SEQUENCE]) begin
			if (seq_pos_q >= seq_len) begin
				seq_pos_d = '0;
			end else if (item_s1.event_code == code_at(seq_codes_q, seq_pos_q)) begin
				if (seq_next >= seq_len) begin
					seq_fire  = 1'b1;
					seq_pos_d = '0;
				end else begin
					seq_pos_d = seq_next;
				end
			end else if (item_s1.event_code == code_at(seq_codes_q, '0)) begin
				seq_pos_d = POS_W'(1);
			end else begin
				seq_pos_d = '0;
			end
		end

		if ((is_key || is_rel) && enables_q[EN_ROTARY]) begin
			if (rot_pos_q >= rot_len) begin
				rot_pos_d = '0;
			end else if (rot_kind_len_q[{1'b0, rot_pos_q}] != is_rel) begin
				rot_pos_d = '0;
			end else if (is_key) begin
				if ((item_s1.event_code == code_at(rot_codes_q, rot_pos_q))
						&& (item_s1.event_value[VALUE_W-1:POS_W] == '0)
						&& (item_s1.event_value[POS_W-1:0] < rot_len))
					rot_pos_d = item_s1.event_value[POS_W-1:0];
				else
					rot_pos_d = '0;
			end else if (item_s1.event_code == code_at(rot_codes_q, rot_pos_q)) begin
				if (rot_next >= rot_len) begin
					rot_fire  = 1'b1;
					rot_pos_d = '0;
				end else begin
					rot_pos_d = rot_next;
				end
			end else if (item_s1.event_code != AXIS_X) begin
				rot_pos_d = '0;
			end
		end
	end

	assign count_cfg.enable       = enables_q[EN_COUNT];
	assign count_cfg.debug        = enables_q[EN_DEBUG];
	assign count_cfg.key_code     = count_key_q;
	assign count_cfg.window_ticks = count_window_q;
	assign count_cfg.entries      = count_table_q;

	kspcd_counter #(
		.COUNT_ENTRIES(COUNT_ENTRIES)
	) u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (count_cfg),
		.mask   (mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_pos_q <= '0;
			rot_pos_q <= '0;
		end else if (advance) begin
			seq_pos_q <= seq_pos_d;
			rot_pos_q <= rot_pos_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seq_fired_q <= seq_fire;
			rot_fired_q <= rot_fire;
			mask_q      <= mask;
		end
	end

	assign result_valid     = result_valid_q;
	assign sequence_fired   = seq_fired_q;
	assign rotary_fired     = rot_fired_q;
	assign count_fired_mask = mask_q;

endmodule

FILE: src/kspcd_checker.sv
`timescale 1ns / 1ps

module kspcd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 event_stall,
	input logic                                 result_valid,
	input logic                                 result_stall,
	input logic                                 sequence_fired,
	input logic                                 rotary_fired,
	input logic [kspcd_pkg::TABLE_ENTRIES-1:0]  count_fired_mask,
	input logic                                 cfg_ready
);

	// a waiting item stays
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result item dropped under stall");

	// hold payload under stall
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(sequence_fired) && $stable(rotary_fired)
			&& $stable(count_fired_mask))
		else $error("result payload changed under stall");

	// ticks and events never report together
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (count_fired_mask != '0) |-> !sequence_fired && !rotary_fired)
		else $error("window expiry reported with an event match");

	// an empty result register never backs up the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !event_stall)
		else $error("input stalled with no result pending");

	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

endmodule

bind key_sequence_and_press_count_detector kspcd_checker u_kspcd_checker (.*);

FILE: tb/detection_checker.sv
`timescale 1ns / 1ps

module detection_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  event_valid,
	input  logic                                  event_stall,
	input  logic                                  action,
	input  logic [kspcd_pkg::TYPE_W-1:0]          event_type,
	input  logic [kspcd_pkg::CODE_W-1:0]          event_code,
	input  logic signed [kspcd_pkg::VALUE_W-1:0]  event_value,
	input  logic                                  result_valid,
	input  logic                                  result_stall,
	input  logic                                  sequence_fired,
	input  logic                                  rotary_fired,
	input  logic [kspcd_pkg::TABLE_ENTRIES-1:0]   count_fired_mask,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [2:0]                            cfg_index,
	input  logic [kspcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                    failures,
	output int                                    pending
);
	import kspcd_pkg::*;

	typedef struct packed {
		logic                     sequence_fired;
		logic                     rotary_fired;
		logic [TABLE_ENTRIES-1:0] count_fired_mask;
	} detection_t;

	logic [ENABLES_W-1:0]  enables;
	logic [CODES_W-1:0]    seq_codes;
	logic [POS_W-1:0]      seq_len;
	logic [CODES_W-1:0]    rot_codes;
	logic [KIND_LEN_W-1:0] rot_kind_len;
	logic [CODE_W-1:0]     count_key;
	logic [WIN_W-1:0]      count_window;
	logic [TABLE_W-1:0]    count_table;

	logic [POS_W-1:0] seq_pos;
	logic [POS_W-1:0] rot_pos;
	logic [CNT_W-1:0] press_count;
	logic             window_open;
	logic [WIN_W-1:0] window_left;

	detection_t expected_detections[$];

	function automatic int clamp_length(input logic [POS_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > MAX_SEQUENCE_DEF)
			return MAX_SEQUENCE_DEF;
		return int'(len);
	endfunction

	function automatic logic advance_rotary(input logic [TYPE_W-1:0] typ,
			input logic [CODE_W-1:0] code, input logic signed [VALUE_W-1:0] val);
		int len;
		int p;
		logic [TYPE_W-1:0] want;
		len = clamp_length(rot_kind_len[8:6]);
		p = int'(rot_pos);
		if (p >= len) begin
			rot_pos = '0;
			return 1'b0;
		end
		want = rot_kind_len[p] ? TYPE_REL : TYPE_KEY;
		if (want != typ) begin
			rot_pos = '0;
			return 1'b0;
		end
		if (typ == TYPE_KEY) begin
			if (code == rot_codes[CODE_W*p +: CODE_W] && val >= 0 && val < len)
				rot_pos = val[POS_W-1:0];
			else
				rot_pos = '0;
			return 1'b0;
		end
		if (code == rot_codes[CODE_W*p +: CODE_W]) begin
			p++;
			if (p >= len) begin
				rot_pos = '0;
				return 1'b1;
			end
			rot_pos = POS_W'(p);
			return 1'b0;
		end
		if (code == AXIS_X)
			return 1'b0;
		rot_pos = '0;
		return 1'b0;
	endfunction

	function automatic detection_t predict_detections(input logic act,
			input logic [TYPE_W-1:0] typ, input logic [CODE_W-1:0] code,
			input logic signed [VALUE_W-1:0] val);
		detection_t d;
		int len;
		int p;
		logic [ENTRY_W-1:0] entry;
		d = '0;
		if (act == ACTION_TICK) begin
			if (window_open) begin
				if (window_left > 1) begin
					window_left--;
				end else begin
					for (int i = 0; i < TABLE_ENTRIES; i++) begin
						entry = count_table[ENTRY_W*i +: ENTRY_W];
						if (entry[CNT_W-1:0] == press_count && (entry[8] || enables[EN_DEBUG]))
							d.count_fired_mask[i] = 1'b1;
					end
					press_count = '0;
					window_open = 1'b0;
					window_left = '0;
				end
			end
		end else if (typ == TYPE_KEY) begin
			if (enables[EN_COUNT] && code == count_key && val != 0) begin
				if (!window_open) begin
					press_count = CNT_W'(1);
					window_open = 1'b1;
					window_left = count_window;
				end else if (press_count != COUNT_MAX) begin
					press_count++;
				end
			end
			if (enables[EN_SEQUENCE]) begin
				len = clamp_length(seq_len);
				p = int'(seq_pos);
				if (p >= len) begin
					p = 0;
				end else if (code == seq_codes[CODE_W*p +: CODE_W]) begin
					p++;
					if (p >= len) begin
						d.sequence_fired = 1'b1;
						p = 0;
					end
				end else if (code == seq_codes[CODE_W-1:0]) begin
					p = 1;
				end else begin
					p = 0;
				end
				seq_pos = POS_W'(p);
			end
			if (enables[EN_ROTARY])
				d.rotary_fired = advance_rotary(typ, code, val);
		end else if (typ == TYPE_REL) begin
			if (enables[EN_ROTARY])
				d.rotary_fired = advance_rotary(typ, code, val);
		end
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		detection_t got;
		detection_t want;
		if (!arst_n) begin
			enables = '0;
			seq_codes = '0;
			seq_len = POS_W'(1);
			rot_codes = '0;
			rot_kind_len = 9'd64;
			count_key = '0;
			count_window = DEFAULT_WINDOW;
			count_table = '0;
			seq_pos = '0;
			rot_pos = '0;
			press_count = '0;
			window_open = 1'b0;
			window_left = '0;
			expected_detections.delete();
			pending = 0;
			failures = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = '{sequence_fired, rotary_fired, count_fired_mask};
				if (expected_detections.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: result with no item pending: seq %b rot %b mask %b",
							$realtime, got.sequence_fired, got.rotary_fired,
							got.count_fired_mask);
				end else begin
					want = expected_detections.pop_front();
					if (got.sequence_fired !== want.sequence_fired
							|| got.rotary_fired !== want.rotary_fired
							|| got.count_fired_mask !== want.count_fired_mask) begin
						failures++;
						if (failures <= 10)
							$display("%0t: mismatch exp/got seq %b/%b rot %b/%b mask %b/%b",
								$realtime, want.sequence_fired, got.sequence_fired,
								want.rotary_fired, got.rotary_fired,
								want.count_fired_mask, got.count_fired_mask);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ENABLES:      enables = cfg_data[ENABLES_W-1:0];
					REG_SEQ_CODES:    seq_codes = cfg_data[CODES_W-1:0];
					REG_SEQ_LENGTH:   seq_len = cfg_data[POS_W-1:0];
					REG_ROT_CODES:    rot_codes = cfg_data[CODES_W-1:0];
					REG_ROT_KIND_LEN: rot_kind_len = cfg_data[KIND_LEN_W-1:0];
					REG_COUNT_KEY:    count_key = cfg_data[CODE_W-1:0];
					REG_COUNT_WINDOW: count_window = cfg_data[WIN_W-1:0];
					REG_COUNT_TABLE:  count_table = cfg_data[TABLE_W-1:0];
					default: ;
				endcase
			end
			if (event_valid && !event_stall)
				expected_detections.push_back(predict_detections(action, event_type,
					event_code, event_value));
			pending = expected_detections.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import kspcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_SETTING = 280;

	logic                      clk;
	logic                      arst_n;
	logic                      event_valid;
	logic                      event_stall;
	logic                      action;
	logic [TYPE_W-1:0]         event_type;
	logic [CODE_W-1:0]         event_code;
	logic signed [VALUE_W-1:0] event_value;
	logic                      result_valid;
	logic                      result_stall;
	logic                      sequence_fired;
	logic                      rotary_fired;
	logic [TABLE_ENTRIES-1:0]  count_fired_mask;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [2:0]                cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	int failures;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int live_items;
	logic burst_go;
	logic burst_done;

	logic [ENABLES_W-1:0]  cur_en;
	logic [CODES_W-1:0]    cur_seq_codes;
	logic [POS_W-1:0]      cur_seq_len;
	logic [CODES_W-1:0]    cur_rot_codes;
	logic [KIND_LEN_W-1:0] cur_rot_kind_len;
	logic [CODE_W-1:0]     cur_count_key;
	logic [WIN_W-1:0]      cur_window;
	logic [TABLE_W-1:0]    cur_table;

	key_sequence_and_press_count_detector i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.event_valid      (event_valid),
		.event_stall      (event_stall),
		.action           (action),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.sequence_fired   (sequence_fired),
		.rotary_fired     (rotary_fired),
		.count_fired_mask (count_fired_mask),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	detection_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.event_valid      (event_valid),
		.event_stall      (event_stall),
		.action           (action),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.sequence_fired   (sequence_fired),
		.rotary_fired     (rotary_fired),
		.count_fired_mask (count_fired_mask),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.failures         (failures),
		.pending          (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("key_sequence_and_press_count_detector test failed");
		$finish;
	end

	// receiver: random stall, plus one long hold-off once requested
	initial begin
		result_stall = 1'b0;
		burst_done = 1'b0;
		forever begin
			@(negedge clk);
			if (burst_go && !burst_done) begin
				result_stall = 1'b1;
				repeat (300) @(negedge clk);
				burst_done = 1'b1;
			end
			result_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	function automatic int clamp_len(input logic [POS_W-1:0] len);
		return (len == 0) ? 1 : ((len > MAX_SEQUENCE_DEF) ? MAX_SEQUENCE_DEF : int'(len));
	endfunction

	function automatic logic signed [VALUE_W-1:0] key_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom;
			default: return $urandom_range(0, 2);
		endcase
	endfunction

	function automatic logic [CODES_W-1:0] rand_codes();
		logic [CODES_W-1:0] c;
		c = '0;
		for (int i = 0; i < CODE_SLOTS; i++)
			c[CODE_W*i +: CODE_W] = (i > 0 && $urandom_range(0, 3) == 0) ?
				c[CODE_W-1:0] : CODE_W'($urandom_range(0, 1023));
		return c;
	endfunction

	function automatic logic [TABLE_W-1:0] rand_table();
		logic [TABLE_W-1:0] t;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			t[ENTRY_W*i +: ENTRY_W] = {1'($urandom_range(0, 1)), 8'($urandom_range(0, 6))};
		return t;
	endfunction

	// hold the item until accepted; entered and left at a falling edge
	task automatic send_item(input logic act, input logic [TYPE_W-1:0] typ,
			input logic [CODE_W-1:0] code, input logic signed [VALUE_W-1:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			event_valid = 1'b0;
			@(negedge clk);
		end
		action = act;
		event_type = typ;
		event_code = code;
		event_value = val;
		event_valid = 1'b1;
		@(posedge clk);
		while (event_stall)
			@(posedge clk);
		@(negedge clk);
		if (act == ACTION_TICK || typ == TYPE_KEY || typ == TYPE_REL)
			live_items++;
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain();
		event_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_setting(input int s);
		cur_seq_codes = rand_codes();
		cur_rot_codes = rand_codes();
		cur_count_key = CODE_W'($urandom_range(0, 1023));
		cur_table = rand_table();
		case (s)
			0: begin
				cur_en = 4'hF;
				cur_seq_len = 3'd3;
				cur_rot_kind_len = {3'd4, 6'($urandom_range(0, 63))};
				cur_window = 16'd3;
			end
			1: begin
				cur_en = 4'h7;
				cur_seq_len = 3'd0;
				cur_rot_kind_len = {3'd7, 6'($urandom_range(0, 63))};
				cur_count_key = 10'h3FF;
				cur_window = 16'd0;
			end
			2: begin
				cur_en = 4'hB;
				cur_seq_codes = {CODES_W{1'b1}};
				cur_seq_len = 3'd6;
				cur_rot_codes = '0;
				cur_rot_kind_len = {3'd0, 6'b111111};
				cur_window = 16'hFFFF;
				cur_table = {TABLE_W{1'b1}};
			end
			3: begin
				cur_en = 4'h5;
				cur_seq_len = 3'd2;
				cur_rot_kind_len = {3'd6, 6'b101010};
				cur_window = 16'd1;
				cur_table = {9'h000, 9'h001, 9'h102, 9'h1FF};
			end
			4: begin
				cur_en = 4'($urandom_range(0, 15));
				cur_seq_len = 3'($urandom_range(0, 7));
				cur_rot_kind_len = 9'($urandom_range(0, 511));
				cur_window = 16'($urandom_range(0, 8));
			end
			default: begin
				cur_en = 4'hF;
				cur_seq_len = 3'd7;
				cur_rot_kind_len = {3'd2, 6'($urandom_range(0, 63))};
				cur_count_key = '0;
				cur_window = 16'd2;
			end
		endcase
		write_reg(REG_ENABLES, CFG_DATA_W'(cur_en));
		write_reg(REG_SEQ_CODES, CFG_DATA_W'(cur_seq_codes));
		write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(cur_seq_len));
		write_reg(REG_ROT_CODES, CFG_DATA_W'(cur_rot_codes));
		write_reg(REG_ROT_KIND_LEN, CFG_DATA_W'(cur_rot_kind_len));
		write_reg(REG_COUNT_KEY, CFG_DATA_W'(cur_count_key));
		write_reg(REG_COUNT_WINDOW, CFG_DATA_W'(cur_window));
		write_reg(REG_COUNT_TABLE, CFG_DATA_W'(cur_table));
	endtask

	task automatic random_items(input int n, input logic saturate);
		int start;
		int len;
		int presses;
		int ticks;
		logic signed [VALUE_W-1:0] v;
		start = live_items;
		while (live_items - start < n) begin
			case ($urandom_range(0, 3))
				0: begin
					len = clamp_len(cur_seq_len);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 9) == 0)
							send_item(ACTION_EVENT, TYPE_KEY, CODE_W'($urandom), key_value());
						send_item(ACTION_EVENT, TYPE_KEY, cur_seq_codes[CODE_W*i +: CODE_W],
							key_value());
					end
				end
				1: begin
					len = clamp_len(cur_rot_kind_len[8:6]);
					for (int i = 0; i < len; i++) begin
						if (cur_rot_kind_len[i]) begin
							if ($urandom_range(0, 4) == 0)
								send_item(ACTION_EVENT, TYPE_REL, AXIS_X, $urandom);
							send_item(ACTION_EVENT, TYPE_REL, cur_rot_codes[CODE_W*i +: CODE_W],
								$signed(32'($urandom_range(0, 20))) - 10);
						end else begin
							v = ($urandom_range(0, 9) == 0) ? key_value() : i + 1;
							send_item(ACTION_EVENT, TYPE_KEY, cur_rot_codes[CODE_W*i +: CODE_W], v);
						end
					end
				end
				2: begin
					presses = saturate ? 260 : $urandom_range(1, 6);
					saturate = 1'b0;
					for (int i = 0; i < presses; i++) begin
						v = key_value();
						if (v == 0 && $urandom_range(0, 1) == 0)
							v = 1;
						send_item(ACTION_EVENT, TYPE_KEY, cur_count_key, v);
					end
					ticks = (cur_window > 8) ? $urandom_range(0, 4) :
						$urandom_range(0, int'(cur_window) + 2);
					repeat (ticks)
						send_item(ACTION_TICK, TYPE_W'($urandom), CODE_W'($urandom), $urandom);
				end
				default: begin
					send_item(($urandom_range(0, 9) == 0) ? ACTION_TICK : ACTION_EVENT,
						($urandom_range(0, 4) < 2) ? TYPE_W'($urandom) :
						(($urandom_range(0, 1) == 0) ? TYPE_KEY : TYPE_REL),
						CODE_W'($urandom), ($urandom_range(0, 1) == 0) ? $urandom : key_value());
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		event_valid = 1'b0;
		action = ACTION_EVENT;
		event_type = '0;
		event_code = '0;
		event_value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ENABLES;
		cfg_data = '0;
		send_idle_pct = 16;
		recv_idle_pct = 64;
		live_items = 0;
		burst_go = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_ENABLES, CFG_DATA_W'(4'hF));
		write_reg(REG_SEQ_CODES, {10'd19, 10'd18, 10'd17, 10'd46, 10'd48, 10'd30});
		write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(3'd3));
		write_reg(REG_ROT_CODES, {30'd0, 10'd8, 10'd8, 10'd28});
		write_reg(REG_ROT_KIND_LEN, CFG_DATA_W'({3'd3, 6'b000110}));
		write_reg(REG_COUNT_KEY, CFG_DATA_W'(10'd116));
		write_reg(REG_COUNT_WINDOW, CFG_DATA_W'(16'd3));
		write_reg(REG_COUNT_TABLE, CFG_DATA_W'({9'h000, 9'h1FF, 9'h103, 9'h002}));

		// plain match, then restart on a repeated first code
		send_item(ACTION_EVENT, TYPE_KEY, 10'd30, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd48, 0);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd46, 2);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd30, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd30, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd48, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd46, 1);
		// rotary: key sets position, X axis ignored, wheel completes
		send_item(ACTION_EVENT, TYPE_KEY, 10'd28, 1);
		send_item(ACTION_EVENT, TYPE_REL, AXIS_X, -5);
		send_item(ACTION_EVENT, TYPE_REL, 10'd8, 1);
		send_item(ACTION_EVENT, TYPE_REL, 10'd8, 32'sh7FFF_FFFF);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd28, -1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd28, 3);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd28, 32'sh8000_0000);
		send_item(ACTION_EVENT, 5'd31, 10'h3FF, 0);
		// press window: release not counted, expire on third tick
		send_item(ACTION_EVENT, TYPE_KEY, 10'd116, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd116, 2);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd116, 0);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd116, -7);
		repeat (4) send_item(ACTION_TICK, '0, '0, '0);
		// shrink lengths under a live position
		send_item(ACTION_EVENT, TYPE_KEY, 10'd28, 2);
		drain();
		write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(3'd6));
		send_item(ACTION_EVENT, TYPE_KEY, 10'd30, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd48, 1);
		send_item(ACTION_EVENT, TYPE_KEY, 10'd46, 1);
		drain();
		write_reg(REG_SEQ_LENGTH, CFG_DATA_W'(3'd2));
		write_reg(REG_ROT_KIND_LEN, CFG_DATA_W'({3'd1, 6'b000110}));
		send_item(ACTION_EVENT, TYPE_KEY, 10'd30, 1);
		send_item(ACTION_EVENT, TYPE_REL, 10'd8, 1);
		drain();

		for (int s = 0; s < 6; s++) begin
			if (s == 2) begin
				send_idle_pct = 64;
				recv_idle_pct = 16;
			end else if (s == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				burst_go = 1'b1;
			end
			apply_setting(s);
			random_items(ITEMS_PER_SETTING, s == 3);
			drain();
		end

		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("key_sequence_and_press_count_detector test passed");
		else
			$display("key_sequence_and_press_count_detector test failed");
		$finish;
	end

endmodule
